@@ rtl/tcw_pkg.sv @@
`default_nettype none

package tcw_pkg;

   // Operation carried by each input item.
   typedef enum logic [1:0] {
      MODE_PUT       = 2'd0,
      MODE_CLEAR     = 2'd1,
      MODE_BACKSPACE = 2'd2,
      MODE_READ      = 2'd3
   } tcw_mode_type;

   typedef struct packed {
      tcw_mode_type mode;
      logic [7:0]   char_code;
      logic [7:0]   color;
      logic [4:0]   min_row;
      logic [10:0]  cell_index;
   } tcw_req_type;

   typedef struct packed {
      logic [15:0] cell_data;
      logic [10:0] cursor_pos;
   } tcw_rsp_type;

   // A space with light grey on black.
   localparam logic [15:0] BLANK_CELL = 16'h0720;
   localparam logic [7:0]  CH_NEWLINE = 8'd10;
   localparam logic [7:0]  CH_RETURN  = 8'd13;

   typedef enum logic [2:0] {
      ST_INIT_FILL,
      ST_IDLE,
      ST_EXEC,
      ST_COPY,
      ST_FILL,
      ST_FINISH
   } tcw_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_item;
      logic exec;
      logic copy;
      logic fill;
      logic cnt_clear;
      logic emit;
   } tcw_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic out_free;
      logic mode_clear;
      logic scroll;
      logic copy_last;
      logic fill_last;
   } tcw_status_type;

endpackage

`default_nettype wire

@@ rtl/text_console_writer.sv @@
`default_nettype none

// Text console of ROWS x COLS cells (25 x 80 by default) with its own screen
// buffer and cursor. Each cell holds the character in bits 7..0 and the
// attribute in bits 15..8. An item either puts a character (newline and
// carriage return are honored, the cursor wraps at the end of a line and the
// screen scrolls up one row past the bottom), clears the screen, backspaces
// (blanks the previous cell and steps back, never above min_row) or reads a
// cell. Every item yields exactly one result with the read data (zero unless
// reading) and the new cursor position, row * COLS + col, kept to 11 bits.
// The buffer is a single memory with one write and one registered read port,
// and every item is worked on alone. A put character, newline or carriage
// return that does not scroll, a backspace and a read are registered at the
// accept and carried out in the EXEC step, which also writes the result
// register. A clear and a put that scrolls go on from EXEC to walk the
// buffer one cell per cycle: a clear blanks every cell, and a put that
// scrolls copies each row up and then blanks the bottom row; the FINISH
// step then writes the result register. A result still waiting in the
// output register holds the next item in EXEC and in FINISH for as long
// as the result is stalled. After reset the block runs a clearing pass
// that fills the buffer with blanks, and takes no item until it ends. A
// result may sit in the output register while the next item is accepted.

module text_console_writer #(
   parameter int ROWS = 25,
   parameter int COLS = 80
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire tcw_pkg::tcw_req_type req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output tcw_pkg::tcw_rsp_type      rsp_data
);

   // Commands and status between the sequencer and the buffer datapath.
   tcw_pkg::tcw_cmd_type    cmd;
   tcw_pkg::tcw_status_type status;

   // The controller owns the order of the buffer walks; the datapath owns the
   // memory, cursor, sweep counter and result register.
   tcw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   tcw_datapath #(
      .ROWS (ROWS),
      .COLS (COLS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // An accepted item is worked on alone: the input closes right after it.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input accepted while an item is in flight");

   // A result is only produced when the output register can take it.
   assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> status.out_free)
      else $error("result emitted over one still waiting");

   // Only one source drives the buffer write port in any cycle.
   assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.exec, cmd.copy, cmd.fill}))
      else $error("buffer write port driven by more than one source");

   // The clearing pass after reset keeps the input closed.
   assert property (@(posedge clock)
      $fell(reset) |-> req_stall)
      else $error("input open before the clearing pass ended");

endmodule

`default_nettype wire

@@ rtl/tcw_ctrl.sv @@
`default_nettype none

module tcw_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire tcw_pkg::tcw_status_type status,
   output tcw_pkg::tcw_cmd_type      cmd
);

   tcw_pkg::tcw_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tcw_pkg::ST_INIT_FILL;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         tcw_pkg::ST_INIT_FILL: begin
            cmd.fill = 1'b1;
            if (status.fill_last) begin
               state_in = tcw_pkg::ST_IDLE;
            end
         end
         tcw_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = tcw_pkg::ST_EXEC;
            end
         end
         tcw_pkg::ST_EXEC: begin
            // Nothing is committed until the result register can take the item.
            if (status.out_free) begin
               cmd.exec = 1'b1;
               priority if (status.mode_clear) begin
                  cmd.cnt_clear = 1'b1;
                  state_in      = tcw_pkg::ST_FILL;
               end else if (status.scroll) begin
                  cmd.cnt_clear = 1'b1;
                  state_in      = tcw_pkg::ST_COPY;
               end else begin
                  cmd.emit = 1'b1;
                  state_in = tcw_pkg::ST_IDLE;
               end
            end
         end
         tcw_pkg::ST_COPY: begin
            cmd.copy = 1'b1;
            if (status.copy_last) begin
               state_in = tcw_pkg::ST_FILL;
            end
         end
         tcw_pkg::ST_FILL: begin
            cmd.fill = 1'b1;
            if (status.fill_last) begin
               state_in = tcw_pkg::ST_FINISH;
            end
         end
         tcw_pkg::ST_FINISH: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = tcw_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tcw_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

@@ rtl/tcw_datapath.sv @@
`default_nettype none

module tcw_datapath #(
   parameter int ROWS = 25,
   parameter int COLS = 80
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire tcw_pkg::tcw_req_type  req_data,
   input  wire tcw_pkg::tcw_cmd_type  cmd,
   output tcw_pkg::tcw_status_type    status,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output tcw_pkg::tcw_rsp_type       rsp_data
);

   localparam int NCELLS = ROWS * COLS;
   localparam int AW     = $clog2(NCELLS);
   localparam int RW     = $clog2(ROWS);
   localparam int CW     = $clog2(COLS);
   localparam int PW     = (AW > 11) ? AW : 11;

   logic [15:0] screen_mem [NCELLS];
   logic [15:0] rd_data_ff;

   tcw_pkg::tcw_req_type item_ff;
   logic                 rd_ok_ff;
   logic [RW-1:0]        row_ff, row_in;
   logic [CW-1:0]        col_ff, col_in;
   logic [AW-1:0]        cnt_ff, cnt_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   tcw_pkg::tcw_rsp_type rsp_data_ff;

   logic [AW-1:0] cur_addr, bs_addr, rd_addr, wr_addr;
   logic [15:0]   wr_data;
   logic          wr_en, rd_en, req_in_range;
   logic          is_nl, is_cr, col_last, row_last, origin, bs_moved;
   logic [PW-1:0] pos_wide;

   assign cur_addr = AW'(row_ff) * AW'(COLS) + AW'(col_ff);
   assign is_nl    = (item_ff.char_code == tcw_pkg::CH_NEWLINE);
   assign is_cr    = (item_ff.char_code == tcw_pkg::CH_RETURN);
   assign col_last = (col_ff == CW'(COLS - 1));
   assign row_last = (row_ff == RW'(ROWS - 1));
   assign origin   = (row_ff == '0) && (col_ff == '0);
   assign bs_moved = (col_ff != '0) || (8'(row_ff) > 8'(item_ff.min_row));
   // Stepping back one cell, also across a row, is one less in linear terms.
   assign bs_addr  = bs_moved ? (cur_addr - AW'(1)) : cur_addr;

   assign req_in_range = (32'(req_data.cell_index) < NCELLS);

   assign status.out_free   = !rsp_valid_ff || !rsp_stall;
   assign status.mode_clear = (item_ff.mode == tcw_pkg::MODE_CLEAR);
   assign status.scroll     = (item_ff.mode == tcw_pkg::MODE_PUT) && row_last &&
                              (is_nl || (!is_cr && col_last));
   assign status.copy_last  = (cnt_ff == AW'(NCELLS - COLS));
   assign status.fill_last  = (cnt_ff == AW'(NCELLS - 1));

   assign rd_en   = (cmd.load_item && req_in_range &&
                     (req_data.mode == tcw_pkg::MODE_READ)) ||
                    (cmd.copy && !status.copy_last);
   assign rd_addr = cmd.copy ? (cnt_ff + AW'(COLS)) : AW'(req_data.cell_index);

   always_comb begin
      row_in  = row_ff;
      col_in  = col_ff;
      wr_en   = 1'b0;
      wr_addr = cur_addr;
      wr_data = tcw_pkg::BLANK_CELL;
      if (cmd.exec) begin
         unique case (item_ff.mode)
            tcw_pkg::MODE_PUT: begin
               if (is_nl) begin
                  col_in = '0;
                  if (!row_last) begin
                     row_in = row_ff + RW'(1);
                  end
               end else if (is_cr) begin
                  col_in = '0;
               end else begin
                  wr_en   = 1'b1;
                  wr_data = {item_ff.color, item_ff.char_code};
                  if (col_last) begin
                     col_in = '0;
                     if (!row_last) begin
                        row_in = row_ff + RW'(1);
                     end
                  end else begin
                     col_in = col_ff + CW'(1);
                  end
               end
            end
            tcw_pkg::MODE_CLEAR: begin
               row_in = '0;
               col_in = '0;
            end
            tcw_pkg::MODE_BACKSPACE: begin
               if (!origin) begin
                  wr_en   = 1'b1;
                  wr_addr = bs_addr;
                  if (col_ff != '0) begin
                     col_in = col_ff - CW'(1);
                  end else if (bs_moved) begin
                     row_in = row_ff - RW'(1);
                     col_in = CW'(COLS - 1);
                  end
               end
            end
            tcw_pkg::MODE_READ: begin
            end
            default: begin
            end
         endcase
      end
      if (cmd.copy && (cnt_ff != '0)) begin
         wr_en   = 1'b1;
         wr_addr = cnt_ff - AW'(1);
         wr_data = rd_data_ff;
      end
      if (cmd.fill) begin
         wr_en   = 1'b1;
         wr_addr = cnt_ff;
         wr_data = tcw_pkg::BLANK_CELL;
      end
   end

   always_comb begin
      cnt_in = cnt_ff;
      priority if (cmd.cnt_clear) begin
         cnt_in = '0;
      end else if (cmd.copy && !status.copy_last) begin
         cnt_in = cnt_ff + AW'(1);
      end else if (cmd.fill) begin
         cnt_in = status.fill_last ? '0 : (cnt_ff + AW'(1));
      end else begin
         cnt_in = cnt_ff;
      end
   end

   assign pos_wide     = PW'(row_in) * PW'(COLS) + PW'(col_in);
   assign rsp_valid_in = cmd.emit || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         screen_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= screen_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         item_ff  <= req_data;
         rd_ok_ff <= req_in_range;
      end
      if (cmd.emit) begin
         rsp_data_ff.cell_data  <= ((item_ff.mode == tcw_pkg::MODE_READ) && rd_ok_ff) ?
                                   rd_data_ff : 16'd0;
         rsp_data_ff.cursor_pos <= pos_wide[10:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff       <= '0;
         col_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         row_ff       <= row_in;
         col_ff       <= col_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

@@ tb/sv/text_console_writer_tb.sv @@
`timescale 1ns / 100ps

module text_console_writer_tb;

   // Screen geometry of the instance under test.
   localparam int ROWS  = 25;
   localparam int COLS  = 80;
   localparam int CELLS = ROWS * COLS;

   // Cycles with no item accepted on either channel before the run is declared hung.
   // The longest quiet spell is the clearing pass after reset or a clear/scroll
   // walk of the whole buffer, plus stall and gap time, so this is many times that.
   localparam int HANG_LIMIT = 40000;

   logic                 clock;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   tcw_pkg::tcw_req_type req_data  = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   tcw_pkg::tcw_rsp_type rsp_data;

   text_console_writer dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Shadow copy of the console: the screen buffer and the cursor.
   logic [15:0] shadow_screen [0:CELLS-1];
   int unsigned cur_row;
   int unsigned cur_col;

   // Results predicted for accepted items, oldest first.
   tcw_pkg::tcw_rsp_type expected_rsp_q [$];

   int  items_sent  = 0;
   int  fault_count = 0;
   int  idle_cycles = 0;
   // When set, neither side idles or stalls.
   bit  quiet       = 1'b0;

   // ---------------------------------------------------------------------
   // Console behavior, tracked item by item.
   // ---------------------------------------------------------------------

   function automatic void console_clear();
      int i;
      for (i = 0; i < CELLS; i++) begin
         shadow_screen[i] = tcw_pkg::BLANK_CELL;
      end
      cur_row = 0;
      cur_col = 0;
   endfunction

   // Puts one character at the cursor, following newline and carriage return,
   // wrapping at the end of a line and scrolling past the bottom row.
   function automatic void console_put(logic [7:0] ch, logic [7:0] attr);
      int unsigned addr;
      int          i;
      if (ch == tcw_pkg::CH_NEWLINE) begin
         cur_col = 0;
         cur_row++;
      end else if (ch == tcw_pkg::CH_RETURN) begin
         cur_col = 0;
      end else begin
         addr = cur_row * COLS + cur_col;
         if (addr < CELLS) begin
            shadow_screen[addr] = {attr, ch};
         end
         cur_col++;
         if (cur_col >= COLS) begin
            cur_col = 0;
            cur_row++;
         end
      end
      if (cur_row > ROWS - 1) begin
         // Scroll: every row moves up and the new bottom row is blank.
         cur_row = ROWS - 1;
         for (i = 0; i < CELLS - COLS; i++) begin
            shadow_screen[i] = shadow_screen[i + COLS];
         end
         for (i = CELLS - COLS; i < CELLS; i++) begin
            shadow_screen[i] = tcw_pkg::BLANK_CELL;
         end
      end
   endfunction

   // One step back; a row boundary is crossed only while the row is above min_row.
   function automatic void console_step_back(logic [4:0] min_row);
      if (cur_col == 0 && cur_row > min_row) begin
         cur_row--;
         cur_col = COLS - 1;
      end else if (cur_col > 0) begin
         cur_col--;
      end
   endfunction

   function automatic tcw_pkg::tcw_rsp_type console_step(tcw_pkg::tcw_req_type item);
      tcw_pkg::tcw_rsp_type rsp;
      rsp.cell_data = '0;
      case (item.mode)
         tcw_pkg::MODE_PUT: begin
            console_put(item.char_code, item.color);
         end
         tcw_pkg::MODE_CLEAR: begin
            console_clear();
         end
         tcw_pkg::MODE_BACKSPACE: begin
            // Nothing happens at the origin; otherwise blank the previous cell.
            if (!(cur_row == 0 && cur_col == 0)) begin
               console_step_back(item.min_row);
               console_put(8'h20, 8'h07);
               console_step_back(item.min_row);
            end
         end
         default: begin
            if (item.cell_index < CELLS) begin
               rsp.cell_data = shadow_screen[item.cell_index];
            end
         end
      endcase
      rsp.cursor_pos = 11'(cur_row * COLS + cur_col);
      return rsp;
   endfunction

   // ---------------------------------------------------------------------
   // Item builders. Fields that the operation ignores carry random noise.
   // ---------------------------------------------------------------------

   function automatic tcw_pkg::tcw_req_type noise_item();
      tcw_pkg::tcw_req_type item;
      item.mode       = tcw_pkg::tcw_mode_type'($urandom_range(0, 3));
      item.char_code  = 8'($urandom_range(0, 255));
      item.color      = 8'($urandom_range(0, 255));
      item.min_row    = 5'($urandom_range(0, 31));
      item.cell_index = 11'($urandom_range(0, 2047));
      return item;
   endfunction

   function automatic tcw_pkg::tcw_req_type put_item(logic [7:0] ch, logic [7:0] attr);
      tcw_pkg::tcw_req_type item;
      item           = noise_item();
      item.mode      = tcw_pkg::MODE_PUT;
      item.char_code = ch;
      item.color     = attr;
      return item;
   endfunction

   function automatic tcw_pkg::tcw_req_type clear_item();
      tcw_pkg::tcw_req_type item;
      item      = noise_item();
      item.mode = tcw_pkg::MODE_CLEAR;
      return item;
   endfunction

   function automatic tcw_pkg::tcw_req_type backspace_item(logic [4:0] min_row);
      tcw_pkg::tcw_req_type item;
      item         = noise_item();
      item.mode    = tcw_pkg::MODE_BACKSPACE;
      item.min_row = min_row;
      return item;
   endfunction

   function automatic tcw_pkg::tcw_req_type read_item(logic [10:0] index);
      tcw_pkg::tcw_req_type item;
      item            = noise_item();
      item.mode       = tcw_pkg::MODE_READ;
      item.cell_index = index;
      return item;
   endfunction

   // A character byte that is neither newline nor carriage return.
   function automatic logic [7:0] pick_glyph();
      logic [7:0] b;
      do begin
         b = 8'($urandom_range(0, 255));
      end while (b == tcw_pkg::CH_NEWLINE || b == tcw_pkg::CH_RETURN);
      return b;
   endfunction

   // ---------------------------------------------------------------------
   // Sending side.
   // ---------------------------------------------------------------------

   // Offers one item, with a random gap first, and records its expected result
   // at the edge where it is accepted. The valid stays high afterward so that
   // back-to-back items need no extra cycle.
   task automatic send_item(input tcw_pkg::tcw_req_type item);
      while (!quiet && $urandom_range(0, 99) < 11) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall !== 1'b0);
      expected_rsp_q.push_back(console_step(item));
      items_sent++;
   endtask

   // Holds the sender back until every outstanding result has come out.
   task automatic wait_results_drained();
      req_valid <= 1'b0;
      while (expected_rsp_q.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // ---------------------------------------------------------------------
   // Receiving side: random stalls and the result check.
   // ---------------------------------------------------------------------

   always @(posedge clock) begin
      rsp_stall <= !quiet && ($urandom_range(0, 99) < 11);
   end

   always @(posedge clock) begin
      tcw_pkg::tcw_rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (expected_rsp_q.size() == 0) begin
            fault_count++;
            if (fault_count <= 10) begin
               $display("Unexpected result: cell_data %h cursor_pos %0d",
                        rsp_data.cell_data, rsp_data.cursor_pos);
            end
         end else begin
            want = expected_rsp_q.pop_front();
            if (rsp_data.cell_data !== want.cell_data) begin
               fault_count++;
               if (fault_count <= 10) begin
                  $display("cell_data mismatch: expected %h, actual %h",
                           want.cell_data, rsp_data.cell_data);
               end
            end
            if (rsp_data.cursor_pos !== want.cursor_pos) begin
               fault_count++;
               if (fault_count <= 10) begin
                  $display("cursor_pos mismatch: expected %0d, actual %0d",
                           want.cursor_pos, rsp_data.cursor_pos);
               end
            end
         end
      end
   end

   // Watchdog on progress: any accepted item on either channel resets it.
   always @(posedge clock) begin
      if ((req_valid && req_stall === 1'b0) ||
          (rsp_valid === 1'b1 && rsp_stall === 1'b0)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= HANG_LIMIT) begin
         $display("Timeout: no item moved for %0d cycles", HANG_LIMIT);
         $display("Simulation FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Tests.
   // ---------------------------------------------------------------------

   // The buffer must read as blanks after reset, including the last cell,
   // and indexes past the screen read as zero.
   task automatic test_after_reset();
      send_item(read_item(11'd0));
      send_item(read_item(11'(CELLS - 1)));
      send_item(read_item(11'(CELLS)));
      send_item(read_item(11'h7FF));
   endtask

   // Extreme character and attribute bytes, carriage return and newline.
   task automatic test_put_extremes();
      send_item(put_item(8'h00, 8'h00));
      send_item(put_item(8'hFF, 8'hFF));
      send_item(put_item(8'h41, 8'h5A));
      send_item(put_item(tcw_pkg::CH_RETURN, 8'hA5));
      send_item(put_item(8'h42, 8'hC3));
      send_item(put_item(tcw_pkg::CH_NEWLINE, 8'h3C));
      send_item(read_item(11'd0));
      send_item(read_item(11'd1));
      send_item(read_item(11'd2));
   endtask

   // Backspace at the origin, blocked by min_row at the start of a row, with min_row
   // past the bottom, and at the origin again after a clear.
   task automatic test_backspace_cases();
      send_item(backspace_item(5'd0));
      send_item(put_item(tcw_pkg::CH_NEWLINE, 8'h00));
      send_item(put_item(tcw_pkg::CH_NEWLINE, 8'h00));
      send_item(backspace_item(5'd2));
      send_item(backspace_item(5'd31));
      send_item(read_item(11'(2 * COLS)));
      send_item(clear_item());
      send_item(backspace_item(5'd0));
   endtask

   // A clear after writing must blank the written cell and home the cursor.
   task automatic test_clear();
      send_item(put_item(8'h7E, 8'h81));
      send_item(clear_item());
      send_item(read_item(11'd0));
   endtask

   // Walk down to the bottom row, run off the end of it so that the line wraps
   // and the screen scrolls, then newline and backspace on the bottom row.
   task automatic test_wrap_and_scroll();
      int i;
      send_item(clear_item());
      send_item(put_item(8'h58, 8'h1E));
      for (i = 0; i < ROWS - 1; i++) begin
         send_item(put_item(tcw_pkg::CH_NEWLINE, 8'($urandom_range(0, 255))));
      end
      send_item(put_item(8'h4D, 8'hE1));
      send_item(read_item(11'(CELLS - COLS)));
      for (i = 0; i < COLS + 2; i++) begin
         send_item(put_item(pick_glyph(), 8'($urandom_range(0, 255))));
      end
      send_item(read_item(11'd0));
      send_item(read_item(11'(CELLS - 2 * COLS)));
      send_item(read_item(11'(CELLS - COLS - 1)));
      send_item(read_item(11'(CELLS - COLS)));
      send_item(read_item(11'(CELLS - COLS + 1)));
      send_item(put_item(tcw_pkg::CH_RETURN, 8'h00));
      send_item(put_item(tcw_pkg::CH_NEWLINE, 8'h00));
      send_item(read_item(11'(CELLS - 2 * COLS)));
      send_item(read_item(11'(CELLS - 1)));
      // Bottom row, column 0: first held by min_row, then allowed to cross.
      send_item(backspace_item(5'd24));
      send_item(backspace_item(5'd0));
      send_item(read_item(11'(CELLS - COLS - 1)));
   endtask

   // Most often lines of text of random length; also bursts of backspaces and of
   // reads (half near the cursor, half anywhere), fully random items and rare clears.
   task automatic run_console_traffic(input int count);
      int          stop_at;
      int          pick;
      int          n;
      int          i;
      int          pos;
      logic [4:0]  min_row;
      logic [10:0] index;
      stop_at = items_sent + count;
      while (items_sent < stop_at) begin
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            n = $urandom_range(0, 85);
            for (i = 0; i < n; i++) begin
               send_item(put_item(pick_glyph(), 8'($urandom_range(0, 255))));
            end
            send_item(put_item(($urandom_range(0, 4) != 0) ?
                               tcw_pkg::CH_NEWLINE : tcw_pkg::CH_RETURN,
                               8'($urandom_range(0, 255))));
         end else if (pick < 65) begin
            n = $urandom_range(1, 8);
            for (i = 0; i < n; i++) begin
               case ($urandom_range(0, 3))
                  0:       min_row = 5'd0;
                  1:       min_row = 5'(cur_row);
                  2:       min_row = 5'($urandom_range(24, 31));
                  default: min_row = 5'($urandom_range(0, 31));
               endcase
               send_item(backspace_item(min_row));
            end
         end else if (pick < 92) begin
            n = $urandom_range(1, 6);
            for (i = 0; i < n; i++) begin
               if ($urandom_range(0, 1) == 0) begin
                  pos = int'(cur_row * COLS + cur_col) - int'($urandom_range(0, 160));
                  index = 11'((pos < 0) ? 0 : pos);
               end else begin
                  index = 11'($urandom_range(0, 2047));
               end
               send_item(read_item(index));
            end
         end else if (pick < 98) begin
            send_item(noise_item());
         end else begin
            send_item(clear_item());
         end
      end
   endtask

   // The sender stops until the block has delivered everything, then resumes.
   task automatic test_pause_for_results();
      run_console_traffic(40);
      wait_results_drained();
      run_console_traffic(40);
   endtask

   // A long stretch with neither side idling or stalling.
   task automatic test_back_to_back();
      quiet = 1'b1;
      run_console_traffic(300);
      quiet = 1'b0;
   endtask

   task automatic test_random_traffic();
      run_console_traffic(950);
   endtask

   initial begin
      console_clear();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_after_reset();
      test_put_extremes();
      test_backspace_cases();
      test_clear();
      test_wrap_and_scroll();
      test_pause_for_results();
      test_back_to_back();
      test_random_traffic();

      // Let every result come out, then allow a few more cycles so that any
      // stray result is caught before the verdict.
      wait_results_drained();
      repeat (20) @(posedge clock);

      if (fault_count == 0 && expected_rsp_q.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
